### rtl/core/tdsq_pkg.sv
// Shared types and constants of the tail-drop server queue.
package tdsq_pkg;

    // Fixed field widths of the stream and configuration ports.
    localparam int ARRIVAL_W  = 48;
    localparam int DURATION_W = 32;
    localparam int FINISH_W   = 48;
    localparam int LIMIT_W    = 7;
    localparam int IN_TDATA_W = ARRIVAL_W + DURATION_W;

    // Queue limit after reset.
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd1;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RETIRE,
        ST_DECIDE
    } t_state;

    // Strobes from the sequencer to the datapath.
    typedef struct packed {
        logic in_ready;
        logic retire;
        logic decide;
    } t_ctrl;

    // Strobes shared by every cell of the chain.
    typedef struct packed {
        logic retire;
        logic shift;
        logic clear;
    } t_cell_ctl;

endpackage

### rtl/core/tdsq_cell.sv
// One cell of the finish-time chain: a stored time and its occupancy flag.
module tdsq_cell #(
    parameter int TIME_WIDTH = 48
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tdsq_pkg::t_cell_ctl   i_ctl,
    input  logic [TIME_WIDTH-1:0] i_arrival,
    input  logic [TIME_WIDTH-1:0] i_prev_time,
    input  logic                  i_prev_occ,
    output logic [TIME_WIDTH-1:0] o_time,
    output logic                  o_occ
);

    logic [TIME_WIDTH-1:0] r_time;
    logic [TIME_WIDTH-1:0] n_time;
    logic                  r_occ;
    logic                  n_occ;

    // A job retires once its finish time is at or before the arrival.
    // On an append the whole chain moves one cell toward the old end.
    always_comb begin
        n_time = r_time;
        n_occ  = r_occ;
        if (i_ctl.retire) begin
            n_occ = r_occ & (r_time > i_arrival);
        end
        if (i_ctl.shift) begin
            n_time = i_prev_time;
            n_occ  = i_prev_occ;
        end
        if (i_ctl.clear) begin
            n_occ = 1'b0;
        end
    end

    // The occupancy flag is control state; the time needs no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_time <= n_time;
    end

    assign o_time = r_time;
    assign o_occ  = r_occ;

endmodule

### rtl/core/tdsq_ctrl.sv
// Sequencer of the tail-drop server queue: retire cycle, then decide cycle.
module tdsq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_out_free,
    output tdsq_pkg::t_ctrl o_ctrl
);

    tdsq_pkg::t_state r_state;
    tdsq_pkg::t_state n_state;
    logic             w_in_ready;
    logic             w_in_acc;

    // A new transaction is taken when idle or as the decide cycle finishes.
    assign w_in_ready = (r_state == tdsq_pkg::ST_IDLE) ||
                        ((r_state == tdsq_pkg::ST_DECIDE) && i_out_free);
    assign w_in_acc   = i_in_valid && w_in_ready;

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            tdsq_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = tdsq_pkg::ST_RETIRE;
                end
            end
            tdsq_pkg::ST_RETIRE: begin
                n_state = tdsq_pkg::ST_DECIDE;
            end
            tdsq_pkg::ST_DECIDE: begin
                if (i_out_free) begin
                    n_state = w_in_acc ? tdsq_pkg::ST_RETIRE : tdsq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tdsq_pkg::ST_IDLE;
            end
        endcase
    end

    // Output strobes.
    always_comb begin
        o_ctrl.in_ready = w_in_ready;
        o_ctrl.retire   = 1'b0;
        o_ctrl.decide   = 1'b0;
        case (r_state)
            tdsq_pkg::ST_RETIRE: begin
                o_ctrl.retire = 1'b1;
            end
            tdsq_pkg::ST_DECIDE: begin
                o_ctrl.decide = i_out_free;
            end
            default: begin
                o_ctrl.retire = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tdsq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### rtl/core/tail_drop_server_queue.sv
// Top level of the tail-drop server queue: job stream in, verdict stream out.
//
//  Channel   Direction  Payload
//  s_axis    in         tdata: arrival_time, duration; tlast: end_of_batch
//  m_axis    out        tdata: finish_time; tuser: accepted
//  cfg       in         queue_limit, written whenever valid is high
//
// Each job passes a retire state, which retires finished jobs in every
// cell at once, then a decide state, which drops it or appends its new
// finish time and loads the result. The next job is taken in the decide
// cycle; a result waiting in the output register holds the decide cycle.
// Reset is synchronous, active low, and empties the chain immediately.
module tail_drop_server_queue #(
    parameter int QUEUE_DEPTH = 64,
    parameter int TIME_WIDTH  = 48
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Fields from bit 0: arrival_time[47:0], duration[79:48].
    input  logic [tdsq_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                             s_axis_tlast,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // Fields from bit 0: finish_time[47:0].
    output logic [tdsq_pkg::FINISH_W-1:0]    m_axis_tdata,
    // Fields from bit 0: accepted[0].
    output logic                             m_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [tdsq_pkg::LIMIT_W-1:0]     i_cfg_data
);

    localparam int NCELL     = QUEUE_DEPTH + 1;
    localparam int LIM_IDX_W = $clog2(NCELL);
    localparam int SUM_W     = ((TIME_WIDTH > tdsq_pkg::DURATION_W) ?
                                TIME_WIDTH : tdsq_pkg::DURATION_W) + 1;
    localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};

    tdsq_pkg::t_ctrl     w_ctrl;
    tdsq_pkg::t_cell_ctl w_cell_ctl;
    logic                w_out_free;
    logic                w_in_acc;

    logic [LIM_IDX_W-1:0]              r_limit_idx;
    logic [TIME_WIDTH-1:0]             r_arrival;
    logic [tdsq_pkg::DURATION_W-1:0]   r_duration;
    logic                              r_last;
    logic [TIME_WIDTH-1:0]             r_base;
    logic [TIME_WIDTH-1:0]             r_last_finish;
    logic                              r_out_valid;
    logic                              r_out_acc;
    logic [tdsq_pkg::FINISH_W-1:0]     r_out_finish;

    logic [TIME_WIDTH-1:0] w_time [NCELL];
    logic [NCELL-1:0]      w_occ;
    logic [SUM_W-1:0]      w_sum;
    logic [TIME_WIDTH-1:0] w_finish;
    logic                  w_drop;

    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_in_acc   = s_axis_tvalid && w_ctrl.in_ready;

    tdsq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_out_free (w_out_free),
        .o_ctrl     (w_ctrl)
    );

    // Configuration: the limit is stored already clamped to the chain depth.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit_idx <= LIM_IDX_W'(tdsq_pkg::LIMIT_RESET);
        end else if (i_cfg_valid) begin
            if (32'(i_cfg_data) > 32'(QUEUE_DEPTH)) begin
                r_limit_idx <= LIM_IDX_W'(QUEUE_DEPTH);
            end else begin
                r_limit_idx <= LIM_IDX_W'(i_cfg_data);
            end
        end
    end

    // Input capture on each accepted transaction.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_arrival  <= TIME_WIDTH'(s_axis_tdata[tdsq_pkg::ARRIVAL_W-1:0]);
            r_duration <= s_axis_tdata[tdsq_pkg::IN_TDATA_W-1:tdsq_pkg::ARRIVAL_W];
            r_last     <= s_axis_tlast;
        end
    end

    // Service start: the later of arrival and the last finish time.
    always_ff @(posedge i_clk) begin
        if (w_ctrl.retire) begin
            r_base <= (r_arrival > r_last_finish) ? r_arrival : r_last_finish;
        end
    end

    // Finish time with saturation at the largest time value.
    assign w_sum    = SUM_W'(r_base) + SUM_W'(r_duration);
    assign w_finish = (w_sum > SUM_W'(TIME_MAX)) ? TIME_MAX : w_sum[TIME_WIDTH-1:0];

    // More than limit jobs still pending means limit jobs are waiting.
    assign w_drop = w_occ[r_limit_idx];

    assign w_cell_ctl.retire = w_ctrl.retire;
    assign w_cell_ctl.shift  = w_ctrl.decide && !w_drop;
    assign w_cell_ctl.clear  = w_ctrl.decide && r_last;

    // Chain of cells, newest finish time in cell zero.
    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        if (g == 0) begin : g_head
            tdsq_cell #(
                .TIME_WIDTH (TIME_WIDTH)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctl       (w_cell_ctl),
                .i_arrival   (r_arrival),
                .i_prev_time (w_finish),
                .i_prev_occ  (1'b1),
                .o_time      (w_time[g]),
                .o_occ       (w_occ[g])
            );
        end else begin : g_body
            tdsq_cell #(
                .TIME_WIDTH (TIME_WIDTH)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctl       (w_cell_ctl),
                .i_arrival   (r_arrival),
                .i_prev_time (w_time[g-1]),
                .i_prev_occ  (w_occ[g-1]),
                .o_time      (w_time[g]),
                .o_occ       (w_occ[g])
            );
        end
    end

    // Last finish time follows every accepted job and clears at batch end.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_finish <= '0;
        end else if (w_ctrl.decide) begin
            if (r_last) begin
                r_last_finish <= '0;
            end else if (!w_drop) begin
                r_last_finish <= w_finish;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctrl.decide) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.decide) begin
            r_out_acc    <= !w_drop;
            r_out_finish <= w_drop ? '0 : tdsq_pkg::FINISH_W'(w_finish);
        end
    end

    assign s_axis_tready = w_ctrl.in_ready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_acc;
    assign m_axis_tdata  = r_out_finish;
    assign o_cfg_ready   = 1'b1;

endmodule

### rtl/core/tdsq_checker.sv
// Port-level checker of the tail-drop server queue and its bind statement.
module tdsq_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic [tdsq_pkg::FINISH_W-1:0] m_axis_tdata,
    input logic                          m_axis_tuser,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready
);

    // A held result keeps its payload until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // A dropped job reports a zero finish time.
    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("dropped job with nonzero finish time");

    // Jobs are never taken back to back.
    a_in_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("job taken in back-to-back cycles");

    // Reset leaves no result pending.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind tail_drop_server_queue tdsq_checker u_tdsq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);

### dv/tb_tail_drop_server_queue.sv
// Self-checking testbench of the tail-drop server queue with a job-level predictor.
module tb_tail_drop_server_queue;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 64;
    localparam logic [tdsq_pkg::ARRIVAL_W-1:0] TIME_MAX = '1;
    localparam int ITEMS_PER_PHASE = 70;
    localparam int PHASES = 10;

    // One job as it travels on the input stream.
    typedef struct {
        logic [tdsq_pkg::ARRIVAL_W-1:0]  arrival;
        logic [tdsq_pkg::DURATION_W-1:0] duration;
        logic                            last;
    } t_job;

    // One verdict as it travels on the output stream.
    typedef struct {
        logic                          accepted;
        logic [tdsq_pkg::FINISH_W-1:0] finish;
    } t_verdict;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    // Fields from bit 0: arrival_time[47:0], duration[79:48].
    logic [tdsq_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;
    logic                            s_axis_tlast = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    // Fields from bit 0: finish_time[47:0].
    logic [tdsq_pkg::FINISH_W-1:0]   m_axis_tdata;
    // Fields from bit 0: accepted[0].
    logic                            m_axis_tuser;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [tdsq_pkg::LIMIT_W-1:0]    i_cfg_data = '0;

    // Pending stimulus and expected verdicts.
    t_job     job_q[$];
    t_verdict verdict_q[$];

    // Predictor state: finish times of jobs not yet done, oldest first.
    logic [tdsq_pkg::FINISH_W-1:0] busy_until_q[$];
    logic [tdsq_pkg::FINISH_W-1:0] last_finish_m = '0;
    logic [tdsq_pkg::LIMIT_W-1:0]  limit_m = tdsq_pkg::LIMIT_RESET;

    int   error_count = 0;

    // Driver and monitor bookkeeping.
    t_job     cur_job;
    bit       sending = 1'b0;
    int       send_gap = 0;
    int       send_calm = 0;
    int       recv_hold = 0;
    int       recv_calm = 0;
    t_verdict want;

    tail_drop_server_queue #(
        .QUEUE_DEPTH(DEPTH),
        .TIME_WIDTH (tdsq_pkg::ARRIVAL_W)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    // Free-running clock.
    always #2 i_clk = ~i_clk;

    // Idle cycles before the next transaction, with occasional stretches of none.
    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 13);
    endfunction

    // Serves one job: retires finished jobs, then drops or schedules it.
    function automatic t_verdict serve_job(t_job j);
        int unsigned                   eff_limit;
        logic [tdsq_pkg::FINISH_W-1:0] start;
        logic [tdsq_pkg::FINISH_W:0]   sum;
        t_verdict                      v;
        eff_limit = (limit_m > DEPTH) ? DEPTH : limit_m;
        while (busy_until_q.size() != 0 && busy_until_q[0] <= j.arrival)
            void'(busy_until_q.pop_front());
        if (busy_until_q.size() != 0 && busy_until_q.size() - 1 >= eff_limit) begin
            v.accepted = 1'b0;
            v.finish   = '0;
        end else begin
            start = (j.arrival > last_finish_m) ? j.arrival : last_finish_m;
            sum = {1'b0, start} + j.duration;
            // Finish times saturate at the top of the time range.
            v.finish   = sum[tdsq_pkg::FINISH_W] ? TIME_MAX : sum[tdsq_pkg::FINISH_W-1:0];
            v.accepted = 1'b1;
            busy_until_q.push_back(v.finish);
            last_finish_m = v.finish;
        end
        // The end of a batch empties the server; the limit is kept.
        if (j.last) begin
            busy_until_q.delete();
            last_finish_m = '0;
        end
        return v;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] exp_val,
                                   input logic [63:0] got_val);
        error_count++;
        if (error_count <= 40)
            $display("MISMATCH %0d at %0t: %s expected 0x%0h got 0x%0h",
                     error_count, $realtime, what, exp_val, got_val);
    endtask

    // Input stream driver: one job per transaction, random gaps between jobs.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                verdict_q.push_back(serve_job(cur_job));
                sending  = 1'b0;
                send_gap = draw_wait(send_calm);
            end
            if (!sending) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (job_q.size() != 0) begin
                    cur_job = job_q.pop_front();
                    sending = 1'b1;
                end
            end
            s_axis_tvalid <= sending;
            s_axis_tdata  <= {cur_job.duration, cur_job.arrival};
            s_axis_tlast  <= cur_job.last;
        end
    end

    // Output stream monitor: compares each verdict and stalls at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (verdict_q.size() == 0) begin
                    report_mismatch("unexpected verdict, finish_time", 64'd0,
                                    64'(m_axis_tdata));
                end else begin
                    want = verdict_q.pop_front();
                    if (m_axis_tuser !== want.accepted)
                        report_mismatch("accepted", 64'(want.accepted), 64'(m_axis_tuser));
                    if (m_axis_tdata !== want.finish)
                        report_mismatch("finish_time", 64'(want.finish), 64'(m_axis_tdata));
                end
                recv_hold = draw_wait(recv_calm);
            end
            if (recv_hold > 0) begin
                recv_hold--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic add_job(input logic [tdsq_pkg::ARRIVAL_W-1:0] arrival,
                           input logic [tdsq_pkg::DURATION_W-1:0] duration,
                           input logic last);
        t_job j;
        j.arrival  = arrival;
        j.duration = duration;
        j.last     = last;
        job_q.push_back(j);
    endtask

    // One batch of jobs; a noisy batch has unordered arrivals all over the range.
    task automatic add_batch(input int n, input bit noisy);
        logic [tdsq_pkg::ARRIVAL_W:0]    t;
        logic [tdsq_pkg::DURATION_W-1:0] dur;
        int unsigned                     dur_top;
        int unsigned                     step_top;
        int unsigned                     back;
        case ($urandom_range(0, 3))
            0: t = '0;
            1: t = (tdsq_pkg::ARRIVAL_W + 1)'($urandom_range(0, 1000));
            2: t = {1'b0, 16'($urandom_range(0, 16'hFFFF)), 32'($urandom)};
            default: t = {1'b0, TIME_MAX} - $urandom_range(0, 2000);
        endcase
        case ($urandom_range(0, 3))
            0: dur_top = 3;
            1: dur_top = 40;
            2: dur_top = 1000;
            default: dur_top = 100000;
        endcase
        // A short step against a long service keeps the line full.
        step_top = dur_top / $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
            if (noisy) begin
                t = {1'b0, 16'($urandom_range(0, 16'hFFFF)), 32'($urandom)};
            end else if ($urandom_range(0, 63) == 0) begin
                back = $urandom_range(0, step_top * 4 + 1);
                if (t > back)
                    t = t - back;
            end else begin
                t = t + $urandom_range(0, step_top);
                if (t > {1'b0, TIME_MAX})
                    t = {1'b0, TIME_MAX};
            end
            case ($urandom_range(0, 39))
                0: dur = $urandom;
                1: dur = '1;
                2: dur = '0;
                default: dur = $urandom_range(1, dur_top);
            endcase
            add_job(t[tdsq_pkg::ARRIVAL_W-1:0], dur, i == n - 1);
        end
    endtask

    task automatic write_limit(input logic [tdsq_pkg::LIMIT_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do
            @(posedge i_clk);
        while (!(i_cfg_valid && o_cfg_ready));
        limit_m = value;
        i_cfg_valid <= 1'b0;
    endtask

    // Waits until every job is sent and every verdict checked.
    task automatic wait_drained();
        while (job_q.size() != 0 || sending || verdict_q.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Sequence: reset, directed jobs at the reset limit, then random phases.
    initial begin
        logic [tdsq_pkg::LIMIT_W-1:0] limit_plan[0:8];
        logic [tdsq_pkg::LIMIT_W-1:0] lim;
        int                           eff;
        int                           n;
        int                           count;
        limit_plan = '{7'd0, 7'd127, 7'd64, 7'd2, 7'd65, 7'd1, 7'd3, 7'd33, 7'd0};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed jobs: drop at the limit, zero duration, saturation,
        // arrivals out of order and batch ends.
        add_job(48'd0, 32'd1, 1'b0);
        add_job(48'd0, 32'd5, 1'b0);
        add_job(48'd0, 32'd1, 1'b0);
        add_job(48'd6, 32'd0, 1'b0);
        add_job(48'd6, 32'd0, 1'b0);
        add_job(48'hFFFF_FFFF_FFF0, 32'hFFFF_FFFF, 1'b0);
        add_job(TIME_MAX, 32'd1, 1'b1);
        add_job(48'd100, 32'd50, 1'b0);
        add_job(48'd120, 32'd10, 1'b0);
        add_job(48'd50, 32'd1, 1'b0);
        add_job(48'd10, 32'd1, 1'b0);
        add_job(48'd155, 32'd1, 1'b1);
        add_job(48'hAAAA_5555_AAAA, 32'h5555_AAAA, 1'b0);
        add_job(48'h5555_AAAA_5555, 32'hAAAA_5555, 1'b1);
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            lim = (p < 9) ? limit_plan[p] : tdsq_pkg::LIMIT_W'($urandom_range(0, 127));
            write_limit(lim);
            eff = (lim > DEPTH) ? DEPTH : lim;
            count = 0;
            while (count < ITEMS_PER_PHASE) begin
                if (eff >= 32 && $urandom_range(0, 1) == 1)
                    n = $urandom_range(eff + 8, 2 * eff + 8);
                else
                    n = $urandom_range(1, 2 * eff + 8);
                add_batch(n, $urandom_range(0, 7) == 0);
                count += n;
            end
            wait_drained();
        end

        repeat (20) @(posedge i_clk);
        if (error_count == 0)
            $display("tail_drop_server_queue regression: pass");
        else
            $display("tail_drop_server_queue regression: fail");
        $finish;
    end

    // Hang guard far beyond the slowest legal run.
    initial begin
        #(2_000_000);
        $display("tail_drop_server_queue regression: fail");
        $finish;
    end

endmodule
